// ===== sv/anhl_pkg.sv =====
// Shared types and constants for the archive name hash lookup block.
// Used by anhl_hash, anhl_search and archive_name_hash_lookup_top.
// No dependencies.
`default_nettype none

package anhl_pkg;

	// Fixed field widths
	localparam int WORD_W        = 32;
	localparam int CHAR_W        = 8;
	localparam int INDEX_W       = 10;
	localparam int ENTRY_COUNT_W = 11;
	// Width used to compare indexes and counts against the table depth
	localparam int EXT_W         = 17;

	// Defaults
	localparam int                MAX_ENTRIES_DEF = 1024;
	localparam logic [WORD_W-1:0] HASH_KEY_RESET  = 32'h0000_0065;

	// Item kinds
	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_CHAR  = 1'b1
	} opcode_t;

	// Configuration register index (paddr[2])
	typedef enum logic {
		REG_HASH_KEY    = 1'b0,
		REG_ENTRY_COUNT = 1'b1
	} reg_idx_t;

	// One table entry as stored in memory
	typedef struct packed {
		logic [WORD_W-1:0] hash;
		logic [WORD_W-1:0] data_begin;
		logic [WORD_W-1:0] data_end;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Lookup result
	typedef struct packed {
		logic              found;
		logic [WORD_W-1:0] data_begin;
		logic [WORD_W-1:0] data_end;
	} result_t;

	// Search engine status toward the top level
	typedef struct packed {
		logic busy;
		logic done;
	} srch_stat_t;

	// Search sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_CMP,
		S_DONE
	} srch_state_t;

endpackage

`default_nettype wire

// ===== sv/anhl_ram.sv =====
// Single-port-write, single-port-read synchronous RAM, registered read data.
// Holds the sorted entry table. Depends on nothing.
`default_nettype none

module anhl_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int W     = 96
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/anhl_hash.sv =====
// Running multiplicative name hash: hash = sext(char) + hash * key.
// Depends on anhl_pkg.
`default_nettype none

module anhl_hash (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          fold,
	input  wire logic                          last,
	input  wire logic [anhl_pkg::CHAR_W-1:0]   name_char,
	input  wire logic [anhl_pkg::WORD_W-1:0]   hash_key,
	output logic      [anhl_pkg::WORD_W-1:0]   hash_next
);

	logic [anhl_pkg::WORD_W-1:0] running_hash_q;
	logic [anhl_pkg::WORD_W-1:0] prod;
	logic [anhl_pkg::WORD_W-1:0] char_sext;

	// Low word of the product, then add the sign-extended byte
	assign prod      = running_hash_q * hash_key;
	assign char_sext = {{(anhl_pkg::WORD_W - anhl_pkg::CHAR_W){name_char[anhl_pkg::CHAR_W-1]}},
		name_char};
	assign hash_next = prod + char_sext;

	// Hash register, cleared once the last character has been folded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_hash_q <= '0;
		end else if (fold) begin
			running_hash_q <= last ? '0 : hash_next;
		end
	end

endmodule

`default_nettype wire

// ===== sv/anhl_search.sv =====
// Binary search sequencer over the entry RAM (lower-bound search).
// Depends on anhl_pkg; reads the table through the RAM's read port.
`default_nettype none

module anhl_search #(
	parameter int MAX_ENTRIES = anhl_pkg::MAX_ENTRIES_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	input  wire logic [anhl_pkg::WORD_W-1:0]          key,
	input  wire logic [anhl_pkg::ENTRY_COUNT_W-1:0]   entry_count,
	output logic                                      rd_en,
	output logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] rd_addr,
	input  wire anhl_pkg::entry_t                     rd_data,
	input  wire logic                                 res_take,
	output anhl_pkg::srch_stat_t                      stat,
	output anhl_pkg::result_t                         res
);

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	anhl_pkg::srch_state_t state_q, state_d;

	logic [CW-1:0]               lo_q, hi_q, n_q, mid_q;
	logic [anhl_pkg::WORD_W-1:0] key_q;
	logic                        final_q;
	anhl_pkg::result_t           res_q;
	logic [CW:0]                 sum;
	logic [CW-1:0]               mid;
	logic [CW-1:0]               n_sat;

	// Count saturated to the table depth
	assign n_sat = (anhl_pkg::EXT_W'(entry_count) > anhl_pkg::EXT_W'(MAX_ENTRIES)) ?
		CW'(MAX_ENTRIES) : CW'(entry_count);

	assign sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid = sum[CW:1];

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= anhl_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and RAM read request
	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_addr = mid[AW-1:0];
		unique case (state_q)
			anhl_pkg::S_IDLE: begin
				if (start) begin
					state_d = anhl_pkg::S_READ;
				end
			end
			anhl_pkg::S_READ: begin
				if (lo_q < hi_q) begin
					rd_en   = 1'b1;
					state_d = anhl_pkg::S_CMP;
				end else if (lo_q < n_q) begin
					rd_en   = 1'b1;
					rd_addr = lo_q[AW-1:0];
					state_d = anhl_pkg::S_CMP;
				end else begin
					state_d = anhl_pkg::S_DONE;
				end
			end
			anhl_pkg::S_CMP: begin
				state_d = final_q ? anhl_pkg::S_DONE : anhl_pkg::S_READ;
			end
			anhl_pkg::S_DONE: begin
				if (res_take) begin
					state_d = anhl_pkg::S_IDLE;
				end
			end
			default: state_d = anhl_pkg::S_IDLE;
		endcase
	end

	// Search datapath
	always_ff @(posedge clk) begin
		case (state_q)
			anhl_pkg::S_IDLE: begin
				lo_q  <= '0;
				hi_q  <= n_sat;
				n_q   <= n_sat;
				key_q <= key;
				res_q <= '0;
			end
			anhl_pkg::S_READ: begin
				mid_q   <= mid;
				final_q <= !(lo_q < hi_q);
			end
			anhl_pkg::S_CMP: begin
				if (final_q) begin
					// Final probe at lo: hit only on exact match
					if (rd_data.hash == key_q) begin
						res_q.found      <= 1'b1;
						res_q.data_begin <= rd_data.data_begin;
						res_q.data_end   <= rd_data.data_end;
					end
				end else if (rd_data.hash < key_q) begin
					lo_q <= mid_q + CW'(1);
				end else begin
					hi_q <= mid_q;
				end
			end
			default: ;
		endcase
	end

	assign stat.busy = (state_q != anhl_pkg::S_IDLE);
	assign stat.done = (state_q == anhl_pkg::S_DONE);
	assign res       = res_q;

endmodule

`default_nettype wire

// ===== sv/archive_name_hash_lookup_top.sv =====
// Top level of the archive name hash lookup block: APB registers, entry RAM,
// hash folder, search sequencer and output register.
// Depends on anhl_pkg, anhl_ram, anhl_hash and anhl_search.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one request per accepted edge.
//   A write request (opcode OP_WRITE) stores {entry_hash, entry_begin,
//   entry_end} at entry_index; indexes at or above MAX_ENTRIES are
//   dropped. A character request (OP_CHAR) folds name_char into the
//   running hash. A character with name_last set starts a binary
//   search over the first entry_count entries (capped at MAX_ENTRIES).
//   Rate: one request per cycle for writes and non-last characters while
//   the search sequencer is idle. A last character holds in_stall high
//   until the result is taken: each probe is one RAM read state plus one
//   compare state through the single read port, plus one final probe.
//   Output channel (out_valid/out_stall) gives found, data_begin, data_end
//   from an output register; a stalled result holds and the search sequencer
//   waits for it to drain before taking the next request.
//   Reset clears the running hash, hash_key to 0x65 and entry_count to 0.
//   Table contents are not cleared; entries must be written before searched.
`default_nettype none

module archive_name_hash_lookup_top #(
	parameter int MAX_ENTRIES = anhl_pkg::MAX_ENTRIES_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// APB configuration port
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [2:0]                          paddr,
	input  wire logic [31:0]                         pwdata,
	output logic      [31:0]                         prdata,
	output logic                                     pready,
	// Request channel
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic                                opcode,
	input  wire logic [anhl_pkg::INDEX_W-1:0]        entry_index,
	input  wire logic [anhl_pkg::WORD_W-1:0]         entry_hash,
	input  wire logic [anhl_pkg::WORD_W-1:0]         entry_begin,
	input  wire logic [anhl_pkg::WORD_W-1:0]         entry_end,
	input  wire logic [anhl_pkg::CHAR_W-1:0]         name_char,
	input  wire logic                                name_last,
	// Result channel
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic                                     found,
	output logic      [anhl_pkg::WORD_W-1:0]         data_begin,
	output logic      [anhl_pkg::WORD_W-1:0]         data_end
);

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

	logic [anhl_pkg::WORD_W-1:0]        hash_key_q;
	logic [anhl_pkg::ENTRY_COUNT_W-1:0] entry_count_q;
	logic                               cfg_wr;
	logic                               in_acc;
	logic                               is_char;
	logic                               mem_we;
	logic [anhl_pkg::EXT_W-1:0]         idx_ext;
	anhl_pkg::entry_t                   wr_entry;
	anhl_pkg::entry_t                   rd_entry;
	logic [anhl_pkg::ENTRY_W-1:0]       rd_word;
	logic                               rd_en;
	logic [AW-1:0]                      rd_addr;
	logic [anhl_pkg::WORD_W-1:0]        hash_next;
	logic                               srch_start;
	logic                               res_take;
	anhl_pkg::srch_stat_t               stat;
	anhl_pkg::result_t                  res;
	logic                               out_valid_q;
	anhl_pkg::result_t                  out_q;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_key_q    <= anhl_pkg::HASH_KEY_RESET;
			entry_count_q <= '0;
		end else if (cfg_wr) begin
			unique case (anhl_pkg::reg_idx_t'(paddr[2]))
				anhl_pkg::REG_HASH_KEY:    hash_key_q    <= pwdata;
				anhl_pkg::REG_ENTRY_COUNT: entry_count_q <= pwdata[anhl_pkg::ENTRY_COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (anhl_pkg::reg_idx_t'(paddr[2]))
			anhl_pkg::REG_HASH_KEY:    prdata = hash_key_q;
			anhl_pkg::REG_ENTRY_COUNT: prdata = 32'(entry_count_q);
			default:                   prdata = '0;
		endcase
	end

	// Request decode; requests wait while a search runs
	assign in_stall   = stat.busy;
	assign in_acc     = in_valid && !in_stall;
	assign is_char    = (anhl_pkg::opcode_t'(opcode) == anhl_pkg::OP_CHAR);
	assign idx_ext    = anhl_pkg::EXT_W'(entry_index);
	assign mem_we     = in_acc && !is_char && (idx_ext < anhl_pkg::EXT_W'(MAX_ENTRIES));
	assign srch_start = in_acc && is_char && name_last;

	assign wr_entry.hash       = entry_hash;
	assign wr_entry.data_begin = entry_begin;
	assign wr_entry.data_end   = entry_end;

	// Entry table
	anhl_ram #(
		.DEPTH (MAX_ENTRIES),
		.AW    (AW),
		.W     (anhl_pkg::ENTRY_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (idx_ext[AW-1:0]),
		.wdata (wr_entry),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_word)
	);

	assign rd_entry = anhl_pkg::entry_t'(rd_word);

	// Name hash
	anhl_hash u_hash (
		.clk       (clk),
		.arst_n    (arst_n),
		.fold      (in_acc && is_char),
		.last      (name_last),
		.name_char (name_char),
		.hash_key  (hash_key_q),
		.hash_next (hash_next)
	);

	// Search sequencer
	anhl_search #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_search (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (srch_start),
		.key         (hash_next),
		.entry_count (entry_count_q),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_data     (rd_entry),
		.res_take    (res_take),
		.stat        (stat),
		.res         (res)
	);

	// Output register
	assign res_take = stat.done && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign found      = out_q.found;
	assign data_begin = out_q.data_begin;
	assign data_end   = out_q.data_end;

	// Checks
	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		srch_start |=> in_stall)
		else $error("search did not start after last character");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> (data_begin == '0) && (data_end == '0))
		else $error("miss result carries nonzero offsets");

	a_rd_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (anhl_pkg::EXT_W'(rd_addr) < anhl_pkg::EXT_W'(MAX_ENTRIES)))
		else $error("table read beyond depth");

	a_no_wr_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !stat.busy)
		else $error("table write during search");

endmodule

`default_nettype wire
